// ===== sv/fsg_pkg.sv =====
// shared types, constants and the square-root step function for the follow speed governor
package fsg_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_REL_SPEED_EPSILON   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_TIME_FACTOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_MIN_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_MARGIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_APPROACH_SPEED      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOWDOWN_FRACTION   = 3'd5;

    localparam logic [CFG_W-1:0] RST_REL_SPEED_EPSILON   = 16'd1;
    localparam logic [CFG_W-1:0] RST_FOLLOW_TIME_FACTOR  = 16'd737;
    localparam logic [CFG_W-1:0] RST_FOLLOW_MIN_DISTANCE = 16'd1280;
    localparam logic [CFG_W-1:0] RST_CRITICAL_MARGIN     = 16'd51;
    localparam logic [CFG_W-1:0] RST_APPROACH_SPEED      = 16'd853;
    localparam logic [CFG_W-1:0] RST_SLOWDOWN_FRACTION   = 16'd5243;

    // square root pipeline geometry
    localparam int unsigned ROOT_W    = 18;
    localparam int unsigned RAD_W     = 2 * ROOT_W;
    localparam int unsigned REM_W     = ROOT_W + 3;
    localparam int unsigned SQ_STEPS  = 3;
    localparam int unsigned SQ_STAGES = ROOT_W / SQ_STEPS;

    localparam int unsigned SPD_W = 17;   // own speed
    localparam int unsigned DOT_W = 20;   // leader speed along heading, signed

    typedef struct packed {
        logic        hazard;
        logic        light_hazard;
        logic [47:0] own_velocity;
        logic [47:0] lead_velocity;
        logic [47:0] heading;
        logic [15:0] distance_margin;
        logic [15:0] speed_cap;
    } t_in_item;

    typedef struct packed {
        logic        stop_req;
        logic [15:0] target_speed;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] rel_speed_epsilon;
        logic [CFG_W-1:0] follow_time_factor;
        logic [CFG_W-1:0] follow_min_distance;
        logic [CFG_W-1:0] critical_margin;
        logic [CFG_W-1:0] approach_speed;
        logic [CFG_W-1:0] slowdown_fraction;
    } t_cfg;

    // per-item fields that ride alongside the square roots
    typedef struct packed {
        logic                    act;
        logic [15:0]             margin;
        logic [15:0]             cap;
        logic signed [DOT_W-1:0] dot;
    } t_side;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_st;

    // a few digit-by-digit square root steps, two radicand bits each
    function automatic t_sqrt_st sqrt_steps(input t_sqrt_st a);
        t_sqrt_st         st;
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] trial;
        st = a;
        for (int k = 0; k < SQ_STEPS; k++) begin
            sh    = {st.rem[REM_W-3:0], st.rad[RAD_W-1 -: 2]};
            trial = {1'b0, st.root, 2'b01};
            if (sh >= trial) begin
                st.rem  = sh - trial;
                st.root = {st.root[ROOT_W-2:0], 1'b1};
            end else begin
                st.rem  = sh;
                st.root = {st.root[ROOT_W-2:0], 1'b0};
            end
            st.rad = {st.rad[RAD_W-3:0], 2'b00};
        end
        return st;
    endfunction

endpackage

// ===== sv/fsg_front.sv =====
// front stages: component squares and dot products, then their sums
module fsg_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  fsg_pkg::t_in_item               i_item,
    output logic                            o_valid,
    output logic [fsg_pkg::RAD_W-1:0]       o_own_sq,
    output logic [fsg_pkg::RAD_W-1:0]       o_rel_sq,
    output fsg_pkg::t_side                  o_side
);

    logic signed [15:0] own_c [3];
    logic signed [15:0] oth_c [3];
    logic signed [15:0] hd_c  [3];
    logic signed [16:0] dif_c [3];
    logic signed [31:0] n_osq [3];
    logic signed [33:0] n_rsq [3];
    logic signed [31:0] n_dp  [3];

    logic        [31:0] r_osq [3];
    logic        [31:0] r_rsq [3];
    logic signed [31:0] r_dp  [3];
    logic               r_v1;
    logic               r_act1;
    logic        [15:0] r_margin1;
    logic        [15:0] r_cap1;

    logic        [33:0] n_own_sum;
    logic        [33:0] n_rel_sum;
    logic signed [33:0] n_dot_sum;

    logic               r_v2;
    logic        [31:0] r_own_sq;
    logic        [33:0] r_rel_sq;
    fsg_pkg::t_side     r_side2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            own_c[i] = i_item.own_velocity[16*i +: 16];
            oth_c[i] = i_item.lead_velocity[16*i +: 16];
            hd_c[i]  = i_item.heading[16*i +: 16];
            dif_c[i] = 17'(own_c[i]) - 17'(oth_c[i]);
            n_osq[i] = own_c[i] * own_c[i];
            n_rsq[i] = dif_c[i] * dif_c[i];
            n_dp[i]  = oth_c[i] * hd_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_osq[i] <= n_osq[i];
            r_rsq[i] <= n_rsq[i][31:0];
            r_dp[i]  <= n_dp[i];
        end
        r_act1    <= i_item.hazard & ~i_item.light_hazard;
        r_margin1 <= i_item.distance_margin;
        r_cap1    <= i_item.speed_cap;
    end

    always_comb begin
        n_own_sum = 34'(r_osq[0]) + 34'(r_osq[1]) + 34'(r_osq[2]);
        n_rel_sum = 34'(r_rsq[0]) + 34'(r_rsq[1]) + 34'(r_rsq[2]);
        n_dot_sum = 34'(r_dp[0]) + 34'(r_dp[1]) + 34'(r_dp[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_own_sq       <= n_own_sum[31:0];
        r_rel_sq       <= n_rel_sum;
        r_side2.act    <= r_act1;
        r_side2.margin <= r_margin1;
        r_side2.cap    <= r_cap1;
        // arithmetic shift floors toward minus infinity, Q12.22 to Q12.8
        r_side2.dot    <= fsg_pkg::DOT_W'(n_dot_sum >>> 14);
    end

    assign o_valid  = r_v2;
    assign o_own_sq = fsg_pkg::RAD_W'(r_own_sq);
    assign o_rel_sq = fsg_pkg::RAD_W'(r_rel_sq);
    assign o_side   = r_side2;

endmodule

// ===== sv/fsg_sqrt.sv =====
// pipelined integer square root, a few result bits per stage
module fsg_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [fsg_pkg::RAD_W-1:0]    i_rad,
    output logic                         o_valid,
    output logic [fsg_pkg::ROOT_W-1:0]   o_root
);

    logic [fsg_pkg::SQ_STAGES-1:0] r_vld;
    fsg_pkg::t_sqrt_st             r_st [fsg_pkg::SQ_STAGES];
    fsg_pkg::t_sqrt_st             n_st [fsg_pkg::SQ_STAGES];

    for (genvar g = 0; g < fsg_pkg::SQ_STAGES; g++) begin : g_stage
        if (g == 0) begin : g_first
            fsg_pkg::t_sqrt_st src;
            always_comb begin
                src.rad  = i_rad;
                src.rem  = '0;
                src.root = '0;
                n_st[g]  = fsg_pkg::sqrt_steps(src);
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else begin
                    r_vld[g] <= i_valid;
                end
            end
        end else begin : g_next
            always_comb begin
                n_st[g] = fsg_pkg::sqrt_steps(r_st[g-1]);
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else begin
                    r_vld[g] <= r_vld[g-1];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_st[g] <= n_st[g];
        end
    end

    assign o_valid = r_vld[fsg_pkg::SQ_STAGES-1];
    assign o_root  = r_st[fsg_pkg::SQ_STAGES-1].root;

endmodule

// ===== sv/fsg_back.sv =====
// back stages: follow distance and slowdown products, decision, final clamps
module fsg_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [fsg_pkg::ROOT_W-1:0]   i_speed,
    input  logic [fsg_pkg::ROOT_W-1:0]   i_rel,
    input  fsg_pkg::t_side               i_side,
    input  fsg_pkg::t_cfg                i_cfg,
    output logic                         o_done,
    output fsg_pkg::t_out_item           o_result
);

    logic [fsg_pkg::SPD_W-1:0] spd;

    logic                      r_v1;
    logic [fsg_pkg::SPD_W-1:0] r_spd;
    logic [32:0]               r_fprod;
    logic [32:0]               r_sprod;
    logic                      r_relgt;
    fsg_pkg::t_side            r_side1;

    logic [21:0]                        follow;
    logic [fsg_pkg::SPD_W-1:0]          n_floor;
    logic signed [fsg_pkg::DOT_W-1:0]   n_tgt;
    logic signed [fsg_pkg::DOT_W-1:0]   appr;
    logic                               n_stop;

    logic                               r_v2;
    logic signed [fsg_pkg::DOT_W-1:0]   r_tgt;
    logic [fsg_pkg::SPD_W-1:0]          r_floor;
    logic                               r_stop;
    logic [15:0]                        r_cap2;

    logic signed [fsg_pkg::DOT_W-1:0]   clamp;

    logic                               r_done;
    fsg_pkg::t_out_item                 r_res;

    assign spd = i_speed[fsg_pkg::SPD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_done <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_spd   <= spd;
        r_fprod <= 33'(i_cfg.follow_time_factor) * 33'(spd);
        r_sprod <= 33'(i_cfg.slowdown_fraction) * 33'(spd);
        r_relgt <= i_rel > fsg_pkg::ROOT_W'(i_cfg.rel_speed_epsilon);
        r_side1 <= i_side;
    end

    always_comb begin
        follow  = 22'(r_fprod[32:12]) + 22'(i_cfg.follow_min_distance);
        n_floor = r_spd - fsg_pkg::SPD_W'(r_sprod[32:16]);
        appr    = $signed(fsg_pkg::DOT_W'(i_cfg.approach_speed));
        n_tgt   = $signed(fsg_pkg::DOT_W'(r_side1.cap));
        n_stop  = 1'b0;
        if (r_side1.act) begin
            if (r_relgt) begin
                priority if (22'(r_side1.margin) > follow) begin
                    n_tgt = r_side1.dot;
                end else if (r_side1.margin > i_cfg.critical_margin) begin
                    n_tgt = (r_side1.dot > appr) ? r_side1.dot : appr;
                end else begin
                    n_stop = 1'b1;
                end
            end
            if (r_side1.margin < i_cfg.critical_margin) begin
                n_stop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt   <= n_tgt;
        r_floor <= n_floor;
        r_stop  <= n_stop;
        r_cap2  <= r_side1.cap;
    end

    always_comb begin
        clamp = r_tgt;
        if (clamp < $signed(fsg_pkg::DOT_W'(r_floor))) begin
            clamp = $signed(fsg_pkg::DOT_W'(r_floor));
        end
        if (clamp > $signed(fsg_pkg::DOT_W'(r_cap2))) begin
            clamp = $signed(fsg_pkg::DOT_W'(r_cap2));
        end
        if (clamp < 0) begin
            clamp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.stop_req     <= r_stop;
        r_res.target_speed <= clamp[15:0];
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== sv/follow_speed_governor.sv =====
// top level: configuration registers, front stages, two square roots, back stages
//
//  channel   | handshake                       | payload
//  ----------+---------------------------------+----------------------------------
//  item in   | start, busy (always low)        | i_item (t_in_item)
//  result    | o_done strobe, one cycle        | o_result (t_out_item)
//  config    | i_cfg_valid, o_cfg_ready (high) | i_cfg_index, i_cfg_data
//
//  a new item can enter every cycle; each result leaves once it has passed through every stage
//  the path runs through the 6-stage square root pipeline between 2 front and 3 back stages
//  synchronous active-low reset clears valid bits and loads the register defaults
//  nothing stalls: results are shown for exactly one cycle, in item order
module follow_speed_governor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  fsg_pkg::t_in_item                 i_item,
    output logic                              o_done,
    output fsg_pkg::t_out_item                o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fsg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fsg_pkg::CFG_W-1:0]         i_cfg_data
);

    fsg_pkg::t_cfg                 r_cfg;
    logic                          fr_valid;
    logic [fsg_pkg::RAD_W-1:0]     own_sq;
    logic [fsg_pkg::RAD_W-1:0]     rel_sq;
    fsg_pkg::t_side                fr_side;
    logic                          sq_valid;
    logic                          rel_valid;
    logic [fsg_pkg::ROOT_W-1:0]    own_root;
    logic [fsg_pkg::ROOT_W-1:0]    rel_root;
    fsg_pkg::t_side                r_side_dly [fsg_pkg::SQ_STAGES];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rel_speed_epsilon   <= fsg_pkg::RST_REL_SPEED_EPSILON;
            r_cfg.follow_time_factor  <= fsg_pkg::RST_FOLLOW_TIME_FACTOR;
            r_cfg.follow_min_distance <= fsg_pkg::RST_FOLLOW_MIN_DISTANCE;
            r_cfg.critical_margin     <= fsg_pkg::RST_CRITICAL_MARGIN;
            r_cfg.approach_speed      <= fsg_pkg::RST_APPROACH_SPEED;
            r_cfg.slowdown_fraction   <= fsg_pkg::RST_SLOWDOWN_FRACTION;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                fsg_pkg::CFG_REL_SPEED_EPSILON:   r_cfg.rel_speed_epsilon   <= i_cfg_data;
                fsg_pkg::CFG_FOLLOW_TIME_FACTOR:  r_cfg.follow_time_factor  <= i_cfg_data;
                fsg_pkg::CFG_FOLLOW_MIN_DISTANCE: r_cfg.follow_min_distance <= i_cfg_data;
                fsg_pkg::CFG_CRITICAL_MARGIN:     r_cfg.critical_margin     <= i_cfg_data;
                fsg_pkg::CFG_APPROACH_SPEED:      r_cfg.approach_speed      <= i_cfg_data;
                fsg_pkg::CFG_SLOWDOWN_FRACTION:   r_cfg.slowdown_fraction   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fsg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_item   (i_item),
        .o_valid  (fr_valid),
        .o_own_sq (own_sq),
        .o_rel_sq (rel_sq),
        .o_side   (fr_side)
    );

    fsg_sqrt u_sqrt_own (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_rad   (own_sq),
        .o_valid (sq_valid),
        .o_root  (own_root)
    );

    fsg_sqrt u_sqrt_rel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_rad   (rel_sq),
        .o_valid (rel_valid),
        .o_root  (rel_root)
    );

    // sideband delay matching the square root latency
    for (genvar g = 0; g < fsg_pkg::SQ_STAGES; g++) begin : g_dly
        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_side_dly[g] <= fr_side;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_side_dly[g] <= r_side_dly[g-1];
            end
        end
    end

    fsg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sq_valid && rel_valid),
        .i_speed  (own_root),
        .i_rel    (rel_root),
        .i_side   (r_side_dly[fsg_pkg::SQ_STAGES-1]),
        .i_cfg    (r_cfg),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// ===== dv/follow_speed_governor_tb.sv =====
// self-checking testbench for the follow speed governor: directed and random items, checked per result
module follow_speed_governor_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_MAX   = 10;

    // writes to these indexes must be ignored
    localparam logic [fsg_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [fsg_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} t_op_kind;

    typedef struct {
        t_op_kind                          kind;
        fsg_pkg::t_in_item                 item;
        logic [fsg_pkg::CFG_IDX_W-1:0]     idx;
        logic [fsg_pkg::CFG_W-1:0]         data;
        int                                gap;
    } t_op;

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              start       = 1'b0;
    logic                              busy;
    fsg_pkg::t_in_item                 i_item      = '0;
    logic                              o_done;
    fsg_pkg::t_out_item                o_result;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [fsg_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [fsg_pkg::CFG_W-1:0]         i_cfg_data  = '0;

    t_op                ops_q[$];
    fsg_pkg::t_out_item pending_targets_q[$];
    fsg_pkg::t_cfg      cfg_model;
    fsg_pkg::t_cfg      plan_cfg;
    int        hold_cnt    = 0;
    bit        gap_done    = 1'b0;
    int        mismatch_cnt = 0;
    int        cyc         = 0;

    follow_speed_governor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 19; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    function automatic longint lane(logic [47:0] v, int k);
        logic signed [15:0] s;
        s = v[16*k +: 16];
        return longint'(s);
    endfunction

    function automatic fsg_pkg::t_out_item governed_speed(fsg_pkg::t_in_item it,
                                                          fsg_pkg::t_cfg c);
        longint unsigned    sq;
        longint unsigned    rsq;
        longint             dot, speed, rel, follow, target, floor_v, cap, margin, d;
        bit                 stop;
        fsg_pkg::t_out_item r;
        sq     = 0;
        rsq    = 0;
        dot    = 0;
        stop   = 1'b0;
        cap    = longint'(it.speed_cap);
        margin = longint'(it.distance_margin);
        target = cap;
        for (int k = 0; k < 3; k++) begin
            sq += lane(it.own_velocity, k) * lane(it.own_velocity, k);
        end
        speed = longint'(floor_root(sq));
        if (it.hazard && !it.light_hazard) begin
            for (int k = 0; k < 3; k++) begin
                d    = lane(it.own_velocity, k) - lane(it.lead_velocity, k);
                rsq += d * d;
                dot += lane(it.lead_velocity, k) * lane(it.heading, k);
            end
            rel = longint'(floor_root(rsq));
            dot = dot >>> 14;   // floor toward minus infinity, Q12.22 to Q12.8
            if (rel > longint'(c.rel_speed_epsilon)) begin
                follow = ((longint'(c.follow_time_factor) * speed) >>> 12)
                         + longint'(c.follow_min_distance);
                if (margin > follow) begin
                    target = dot;
                end else if (margin > longint'(c.critical_margin)) begin
                    target = (dot > longint'(c.approach_speed)) ? dot
                                                                : longint'(c.approach_speed);
                end else begin
                    stop = 1'b1;
                end
            end
            if (margin < longint'(c.critical_margin)) stop = 1'b1;
        end
        floor_v = speed - ((longint'(c.slowdown_fraction) * speed) >>> 16);
        if (target < floor_v) target = floor_v;
        if (target > cap) target = cap;
        if (target < 0) target = 0;
        r.stop_req     = stop;
        r.target_speed = target[15:0];
        return r;
    endfunction

    function automatic void apply_cfg(logic [fsg_pkg::CFG_IDX_W-1:0] idx,
                                      logic [fsg_pkg::CFG_W-1:0] data);
        case (idx)
            fsg_pkg::CFG_REL_SPEED_EPSILON:   cfg_model.rel_speed_epsilon   = data;
            fsg_pkg::CFG_FOLLOW_TIME_FACTOR:  cfg_model.follow_time_factor  = data;
            fsg_pkg::CFG_FOLLOW_MIN_DISTANCE: cfg_model.follow_min_distance = data;
            fsg_pkg::CFG_CRITICAL_MARGIN:     cfg_model.critical_margin     = data;
            fsg_pkg::CFG_APPROACH_SPEED:      cfg_model.approach_speed      = data;
            fsg_pkg::CFG_SLOWDOWN_FRACTION:   cfg_model.slowdown_fraction   = data;
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic logic [15:0] jitter(int base, int span);
        int v;
        v = base + int'($urandom_range(0, 2 * span)) - span;
        return v[15:0];
    endfunction

    function automatic logic [47:0] v3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic fsg_pkg::t_in_item mk(bit hz, bit lh, logic [47:0] ov, logic [47:0] hv,
                                             logic [47:0] hd, logic [15:0] m, logic [15:0] c);
        fsg_pkg::t_in_item it;
        it.hazard          = hz;
        it.light_hazard    = lh;
        it.own_velocity    = ov;
        it.lead_velocity   = hv;
        it.heading         = hd;
        it.distance_margin = m;
        it.speed_cap       = c;
        return it;
    endfunction

    function automatic fsg_pkg::t_in_item random_item(fsg_pkg::t_cfg p);
        fsg_pkg::t_in_item it;
        int                sel;
        int                span;
        it.hazard       = ($urandom_range(0, 9) < 8);
        it.light_hazard = ($urandom_range(0, 9) < 2);

        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            it.own_velocity = rand48();
        end else begin
            for (int k = 0; k < 3; k++) it.own_velocity[16*k +: 16] = jitter(0, 12800);
        end

        // leader mostly close to own velocity so closing speed sits near epsilon
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            it.lead_velocity = rand48();
        end else if (sel < 4) begin
            for (int k = 0; k < 3; k++) it.lead_velocity[16*k +: 16] = jitter(0, 12800);
        end else begin
            span = (sel < 7) ? $urandom_range(0, 3) : $urandom_range(0, 400);
            for (int k = 0; k < 3; k++) begin
                it.lead_velocity[16*k +: 16] =
                    jitter(int'($signed(it.own_velocity[16*k +: 16])), span);
            end
        end

        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            it.heading = rand48();
        end else if (sel < 6) begin
            it.heading = '0;
            it.heading[16*$urandom_range(0, 2) +: 16] = $urandom_range(0, 1) ? 16'h4000
                                                                               : 16'hC000;
        end else begin
            for (int k = 0; k < 3; k++) it.heading[16*k +: 16] = jitter(0, 16384);
        end

        sel = $urandom_range(0, 9);
        if (sel < 3)      it.distance_margin = 16'($urandom_range(0, 65535));
        else if (sel < 5) it.distance_margin = jitter(int'(p.critical_margin), 4);
        else if (sel < 8) it.distance_margin = 16'($urandom_range(0, 8192));
        else              it.distance_margin = jitter(int'(p.follow_min_distance) + 512, 600);

        sel = $urandom_range(0, 9);
        if (sel < 4)      it.speed_cap = 16'($urandom_range(0, 65535));
        else if (sel < 6) it.speed_cap = 16'hFFFF;
        else              it.speed_cap = 16'($urandom_range(0, 16384));
        return it;
    endfunction

    task automatic push_item(fsg_pkg::t_in_item it, int gap);
        t_op op;
        op.kind = OP_ITEM;
        op.item = it;
        op.idx  = '0;
        op.data = '0;
        op.gap  = gap;
        ops_q.push_back(op);
    endtask

    task automatic push_cfg(logic [fsg_pkg::CFG_IDX_W-1:0] idx,
                            logic [fsg_pkg::CFG_W-1:0] data);
        t_op op;
        op.kind = OP_CFG;
        op.item = '0;
        op.idx  = idx;
        op.data = data;
        op.gap  = 0;
        ops_q.push_back(op);
    endtask

    task automatic push_drain();
        t_op op;
        op.kind = OP_DRAIN;
        op.item = '0;
        op.idx  = '0;
        op.data = '0;
        op.gap  = 0;
        ops_q.push_back(op);
    endtask

    task automatic set_regs(fsg_pkg::t_cfg c);
        push_cfg(fsg_pkg::CFG_REL_SPEED_EPSILON,   c.rel_speed_epsilon);
        push_cfg(fsg_pkg::CFG_FOLLOW_TIME_FACTOR,  c.follow_time_factor);
        push_cfg(fsg_pkg::CFG_FOLLOW_MIN_DISTANCE, c.follow_min_distance);
        push_cfg(fsg_pkg::CFG_CRITICAL_MARGIN,     c.critical_margin);
        push_cfg(fsg_pkg::CFG_APPROACH_SPEED,      c.approach_speed);
        push_cfg(fsg_pkg::CFG_SLOWDOWN_FRACTION,   c.slowdown_fraction);
        plan_cfg = c;
    endtask

    task automatic random_phase(int n, int idle_pct);
        int gap;
        for (int i = 0; i < n; i++) begin
            gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 14) : 0;
            push_item(random_item(plan_cfg), gap);
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        logic nxt_start;
        logic nxt_cfg_valid;
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            hold_cnt    = 0;
            gap_done    = 1'b0;
            cfg_model   = '{fsg_pkg::RST_REL_SPEED_EPSILON, fsg_pkg::RST_FOLLOW_TIME_FACTOR,
                            fsg_pkg::RST_FOLLOW_MIN_DISTANCE, fsg_pkg::RST_CRITICAL_MARGIN,
                            fsg_pkg::RST_APPROACH_SPEED, fsg_pkg::RST_SLOWDOWN_FRACTION};
        end else begin
            nxt_start     = start;
            nxt_cfg_valid = i_cfg_valid;
            if (start && !busy) begin
                pending_targets_q.push_back(governed_speed(i_item, cfg_model));
                nxt_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_cfg(i_cfg_index, i_cfg_data);
                nxt_cfg_valid = 1'b0;
            end
            if (!nxt_start && !nxt_cfg_valid) begin
                if (hold_cnt > 0) begin
                    hold_cnt--;
                end else if (ops_q.size() > 0) begin
                    if (ops_q[0].gap > 0 && !gap_done) begin
                        hold_cnt = ops_q[0].gap - 1;
                        gap_done = 1'b1;
                    end else begin
                        case (ops_q[0].kind)
                            OP_ITEM: begin
                                nxt_start = 1'b1;
                                i_item   <= ops_q[0].item;
                                gap_done  = 1'b0;
                                void'(ops_q.pop_front());
                            end
                            // registers change only with nothing in flight
                            OP_CFG: begin
                                if (pending_targets_q.size() == 0) begin
                                    nxt_cfg_valid = 1'b1;
                                    i_cfg_index  <= ops_q[0].idx;
                                    i_cfg_data   <= ops_q[0].data;
                                    gap_done      = 1'b0;
                                    void'(ops_q.pop_front());
                                end
                            end
                            OP_DRAIN: begin
                                if (pending_targets_q.size() == 0) begin
                                    gap_done = 1'b0;
                                    void'(ops_q.pop_front());
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            start       <= nxt_start;
            i_cfg_valid <= nxt_cfg_valid;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        fsg_pkg::t_out_item want;
        if (i_rst_n && o_done) begin
            if (pending_targets_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected result: stop=%0d target=%0d",
                             o_result.stop_req, o_result.target_speed);
            end else begin
                want = pending_targets_q.pop_front();
                if (o_result.stop_req !== want.stop_req) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("stop_req mismatch: expected %0d, got %0d",
                                 want.stop_req, o_result.stop_req);
                end
                if (o_result.target_speed !== want.target_speed) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("target_speed mismatch: expected %0d, got %0d",
                                 want.target_speed, o_result.target_speed);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        plan_cfg = '{fsg_pkg::RST_REL_SPEED_EPSILON, fsg_pkg::RST_FOLLOW_TIME_FACTOR,
                     fsg_pkg::RST_FOLLOW_MIN_DISTANCE, fsg_pkg::RST_CRITICAL_MARGIN,
                     fsg_pkg::RST_APPROACH_SPEED, fsg_pkg::RST_SLOWDOWN_FRACTION};

        // directed items under the reset settings
        push_item(mk(0, 0, '0, '0, '0, 16'h0000, 16'h0000), 0);
        push_item(mk(0, 0, v3(16'h7FFF, 16'h7FFF, 16'h7FFF), v3(16'h8000, 16'h8000, 16'h8000),
                     v3(16'h7FFF, 16'h7FFF, 16'h7FFF), 16'hFFFF, 16'hFFFF), 0);
        // largest closing speed, leader against heading
        push_item(mk(1, 0, v3(16'h8000, 16'h8000, 16'h8000), v3(16'h7FFF, 16'h7FFF, 16'h7FFF),
                     v3(16'h8000, 16'h8000, 16'h8000), 16'hFFFF, 16'hFFFF), 0);
        // light hazard suppresses collision handling
        push_item(mk(1, 1, v3(16'h0A00, 0, 0), '0, v3(16'h4000, 0, 0), 16'h0000, 16'hFFFF), 0);
        // closing speed zero and at epsilon: only the gap test can stop
        push_item(mk(1, 0, v3(16'h0A00, 0, 0), v3(16'h0A00, 0, 0), v3(16'h4000, 0, 0),
                     16'd0, 16'hFFFF), 0);
        push_item(mk(1, 0, v3(16'h0A00, 0, 0), v3(16'h0A01, 0, 0), v3(16'h4000, 0, 0),
                     16'd40, 16'hFFFF), 0);
        // leader target raised to the slowdown floor, then capped
        push_item(mk(1, 0, v3(16'h0A00, 0, 0), v3(16'h0500, 0, 0), v3(16'h4000, 0, 0),
                     16'd4000, 16'hFFFF), 3);
        push_item(mk(1, 0, v3(16'h0A00, 0, 0), v3(16'h0500, 0, 0), v3(16'h4000, 0, 0),
                     16'd4000, 16'h0100), 0);
        // negative leader speed
        push_item(mk(1, 0, v3(16'h0A00, 0, 0), v3(16'hFB00, 0, 0), v3(16'h4000, 0, 0),
                     16'd4000, 16'hFFFF), 0);
        push_item(mk(1, 0, '0, v3(16'hFB00, 0, 0), v3(16'h4000, 0, 0), 16'd4000, 16'hFFFF), 0);
        // approach band: leader slower and faster than approach speed
        push_item(mk(1, 0, v3(16'h0200, 0, 0), v3(16'h0080, 0, 0), v3(16'h4000, 0, 0),
                     16'd1000, 16'hFFFF), 0);
        push_item(mk(1, 0, v3(16'h0200, 0, 0), v3(16'h0600, 0, 0), v3(16'h4000, 0, 0),
                     16'd1000, 16'hFFFF), 0);
        // gap exactly at follow distance
        push_item(mk(1, 0, v3(16'h0200, 0, 0), v3(16'h0080, 0, 0), v3(16'h4000, 0, 0),
                     16'd1372, 16'hFFFF), 0);
        // gap exactly at critical margin, with and without closing speed
        push_item(mk(1, 0, v3(16'h0200, 0, 0), v3(16'h0080, 0, 0), v3(16'h4000, 0, 0),
                     16'd51, 16'hFFFF), 0);
        push_item(mk(1, 0, v3(16'h0200, 0, 0), v3(16'h0200, 0, 0), v3(16'h4000, 0, 0),
                     16'd51, 16'hFFFF), 0);
        push_item(mk(1, 0, v3(16'h0200, 0, 0), v3(16'h0080, 0, 0), v3(16'h4000, 0, 0),
                     16'd52, 16'hFFFF), 0);
        push_item(mk(1, 0, v3(16'h0200, 0, 0), v3(16'h0080, 0, 0), v3(16'h4000, 0, 0),
                     16'd50, 16'hFFFF), 0);
        push_item(mk(1, 0, v3(16'h0A00, 0, 0), v3(16'h0500, 0, 0), v3(16'h4000, 0, 0),
                     16'd4000, 16'h0000), 0);
        push_item(mk(1, 0, v3(0, 16'h0300, 16'h0100), v3(0, 16'h0100, 16'h0400),
                     v3(0, 16'hC000, 0), 16'h3000, 16'hFFFF), 0);
        push_item(mk(1, 0, v3(16'hF800, 16'h0400, 16'hFF00), v3(16'h0200, 16'hFC00, 16'h0100),
                     v3(16'h2D41, 16'hD2BF, 16'h0000), 16'h2000, 16'h4000), 0);
        push_item(mk(0, 1, v3(16'h8000, 16'h8000, 16'h8000), '0, '0, 16'h0000, 16'h8000), 0);

        set_regs('{16'd32, 16'd4096, 16'd2560, 16'd256, 16'd1280, 16'd6554});
        random_phase(280, 30);

        set_regs('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
        random_phase(250, 20);

        set_regs('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        random_phase(250, 20);

        set_regs('{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom)});
        random_phase(250, 25);

        set_regs('{16'($urandom_range(0, 512)), 16'($urandom_range(0, 16384)),
                   16'($urandom_range(0, 4096)), 16'($urandom_range(0, 512)),
                   16'($urandom_range(0, 4096)), 16'($urandom_range(0, 32768))});
        push_cfg(CFG_SPARE_LO, 16'hFFFF);
        push_cfg(CFG_SPARE_HI, 16'h0000);
        random_phase(250, 25);

        set_regs('{fsg_pkg::RST_REL_SPEED_EPSILON, fsg_pkg::RST_FOLLOW_TIME_FACTOR,
                   fsg_pkg::RST_FOLLOW_MIN_DISTANCE, fsg_pkg::RST_CRITICAL_MARGIN,
                   fsg_pkg::RST_APPROACH_SPEED, fsg_pkg::RST_SLOWDOWN_FRACTION});
        random_phase(150, 25);
        push_drain();
        random_phase(150, 0);

        set_regs('{16'($urandom_range(0, 64)), 16'($urandom_range(1024, 8192)),
                   16'($urandom_range(256, 2048)), 16'($urandom_range(0, 256)),
                   16'($urandom_range(256, 2048)), 16'($urandom_range(1024, 16384))});
        random_phase(350, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_q.size() != 0 || start || i_cfg_valid || pending_targets_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && pending_targets_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/fsg_pkg.sv
sv/fsg_front.sv
sv/fsg_sqrt.sv
sv/fsg_back.sv
sv/follow_speed_governor.sv
dv/follow_speed_governor_tb.sv
